// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during reset
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/mss_pkg.sv =====
// Types and constants of the shared-store multi-stack
`timescale 1ns / 1ps
package mss_pkg;

    localparam int STACK_ID_W = 2;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    localparam logic signed [VALUE_W-1:0] EMPTY_POP_VALUE = -32'sd1;
    localparam logic signed [VALUE_W-1:0] PUSH_RSP_VALUE  = 32'sd0;

    typedef struct packed {
        logic                        action;
        logic [STACK_ID_W-1:0]       stack_id;
        logic signed [VALUE_W-1:0]   push_value;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]         status;
        logic signed [VALUE_W-1:0]   pop_value;
    } out_item_t;

    typedef struct packed {
        logic                        valid;
        out_item_t                   item;
    } res_t;

endpackage

// ===== rtl/mss_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module mss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/mss_ctrl.sv =====
// Pointer control: stack tops, free-list head, fill count and link/value access
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mss_ctrl import mss_pkg::*; #(
    parameter int NUM_STACKS = 4,
    parameter int CAPACITY   = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  in_item_t                         req,
    input  logic                             room,
    output logic                             mem_re,
    output logic [$clog2(CAPACITY)-1:0]      mem_raddr,
    output logic [$clog2(CAPACITY)-1:0]      mem_waddr,
    output logic                             link_we,
    output logic [$clog2(CAPACITY+1)-1:0]    link_wdata,
    input  logic [$clog2(CAPACITY+1)-1:0]    link_rdata,
    output logic                             val_we,
    output logic [VALUE_W-1:0]               val_wdata,
    input  logic [VALUE_W-1:0]               val_rdata,
    output res_t                             res
);

    localparam int ID_SPAN = 1 << STACK_ID_W;
    localparam int TOPS    = (NUM_STACKS < ID_SPAN) ? NUM_STACKS : ID_SPAN;
    localparam int TW      = (TOPS > 1) ? $clog2(TOPS) : 1;
    localparam int AW      = $clog2(CAPACITY);
    localparam int PTR_W   = $clog2(CAPACITY + 1);
    localparam logic [PTR_W-1:0] NULL_PTR  = PTR_W'(CAPACITY);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(CAPACITY - 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t                    state_reg, state_next;
    logic [PTR_W-1:0]          free_head_reg, free_head_next;
    logic [PTR_W-1:0]          fill_reg, fill_next;
    logic [PTR_W-1:0]          top_reg [TOPS];
    logic [PTR_W-1:0]          top_next [TOPS];
    logic                      act_reg;
    logic [TW-1:0]             tidx_reg;
    logic [PTR_W-1:0]          slot_reg;
    logic                      ok_reg;
    logic [VALUE_W-1:0]        val_reg;

    logic                      req_fire;
    logic                      id_ok;
    logic [TW-1:0]             tidx;
    logic [PTR_W-1:0]          slot_sel;
    logic                      fresh;
    logic [PTR_W-1:0]          seq_link;
    logic [PTR_W-1:0]          raw_link;
    logic [PTR_W-1:0]          next_link;

    assign req_ready = (state_reg == ST_IDLE) && room;
    assign req_fire  = req_valid && req_ready;

    assign id_ok    = int'(req.stack_id) < TOPS;
    assign tidx     = id_ok ? TW'(req.stack_id) : '0;
    assign slot_sel = (req.action == ACT_PUSH) ? free_head_reg : top_reg[tidx];

    assign mem_re    = req_fire;
    assign mem_raddr = slot_sel[AW-1:0];
    assign mem_waddr = slot_reg[AW-1:0];

    // slots at or above the fill count were never written; their link is the next slot in sequence
    assign fresh     = slot_reg >= fill_reg;
    assign seq_link  = (slot_reg == LAST_SLOT) ? NULL_PTR : slot_reg + PTR_W'(1);
    assign raw_link  = fresh ? seq_link : link_rdata;
    assign next_link = (raw_link >= NULL_PTR) ? NULL_PTR : raw_link;

    always_comb
    begin
        state_next     = state_reg;
        free_head_next = free_head_reg;
        fill_next      = fill_reg;
        top_next       = top_reg;
        link_we        = 1'b0;
        link_wdata     = free_head_reg;
        val_we         = 1'b0;
        val_wdata      = val_reg;
        res.valid      = 1'b0;
        res.item       = '{status: STATUS_DONE, pop_value: PUSH_RSP_VALUE};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                res.valid  = 1'b1;
                if (act_reg == ACT_PUSH)
                begin
                    if (ok_reg)
                    begin
                        free_head_next   = next_link;
                        top_next[tidx_reg] = slot_reg;
                        link_we          = 1'b1;
                        link_wdata       = top_reg[tidx_reg];
                        val_we           = 1'b1;
                        if (fresh)
                        begin
                            fill_next = fill_reg + PTR_W'(1);
                        end
                    end
                    else
                    begin
                        res.item.status = STATUS_FULL;
                    end
                end
                else
                begin
                    if (ok_reg)
                    begin
                        top_next[tidx_reg] = next_link;
                        link_we          = 1'b1;
                        link_wdata       = free_head_reg;
                        free_head_next   = slot_reg;
                        res.item.pop_value = val_rdata;
                    end
                    else
                    begin
                        res.item.status    = STATUS_EMPTY;
                        res.item.pop_value = EMPTY_POP_VALUE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            free_head_reg <= '0;
            fill_reg      <= '0;
            for (int i = 0; i < TOPS; i++)
            begin
                top_reg[i] <= NULL_PTR;
            end
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            fill_reg      <= fill_next;
            top_reg       <= top_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            act_reg  <= req.action;
            tidx_reg <= tidx;
            slot_reg <= slot_sel;
            ok_reg   <= id_ok && (slot_sel < NULL_PTR);
            val_reg  <= req.push_value;
        end
    end

    `ASSERT_NEXT(a_exec_after_accept, req_fire, state_reg == ST_EXEC)
    `ASSERT_IMPL(a_fill_in_range, 1'b1, fill_reg <= NULL_PTR)
    `ASSERT_IMPL(a_head_in_range, 1'b1, free_head_reg <= NULL_PTR)
    `ASSERT_IMPL(a_fresh_is_fill, (state_reg == ST_EXEC) && ok_reg && fresh, (act_reg == ACT_PUSH) && (slot_reg == fill_reg))

endmodule

// ===== rtl/mss_outq.sv =====
// Result output register with one hold stage behind it
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mss_outq import mss_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  res_t      res,
    output logic      room,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output out_item_t rsp
);

    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg, out_data_next;
    logic      hold_valid_reg, hold_valid_next;
    out_item_t hold_data_reg, hold_data_next;
    logic      out_free;

    assign out_free  = !out_valid_reg || rsp_ready;
    assign room      = !hold_valid_reg;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        hold_valid_next = hold_valid_reg;
        hold_data_next  = hold_data_reg;
        priority if (out_free && hold_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_data_next   = hold_data_reg;
            hold_valid_next = res.valid;
            hold_data_next  = res.item;
        end
        else if (out_free)
        begin
            out_valid_next = res.valid;
            out_data_next  = res.item;
        end
        else if (res.valid)
        begin
            hold_valid_next = 1'b1;
            hold_data_next  = res.item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        hold_data_reg <= hold_data_next;
    end

    `ASSERT_IMPL(a_hold_behind_out, hold_valid_reg, out_valid_reg)
    `ASSERT_IMPL(a_no_overrun, res.valid, !hold_valid_reg)

endmodule

// ===== rtl/shared_store_multi_stack.sv =====
// Several LIFO stacks sharing one value store, linked through a free list
// Request channel (req_valid/req_ready/req): action, stack_id, push_value.
// Response channel (rsp_valid/rsp_ready/rsp): status, pop_value; one per request.
// A request transfer reads the link and value memories at the free-list head
// (push) or the addressed stack top (pop); the next cycle writes the link (and, on a
// push, the value) back and updates the head, the top and, on a push, the fill count.
// The response is built in the execute state and registered in the output
// register, or parked in the hold stage while the output is stalled. A new
// request is taken only after the read-then-write on the link memory.
// Reset: all stacks empty, free list runs slot 0 to CAPACITY-1. Never-used
// slots are tracked by a fill count, so no clearing pass is needed and the
// block takes requests right after reset.
// Stall: a finished response waits in the output register; one more request
// is taken and its response parked in a hold stage, then req_ready drops
// until the receiver drains the output.
`timescale 1ns / 1ps
module shared_store_multi_stack import mss_pkg::*; #(
    parameter int NUM_STACKS = 4,
    parameter int CAPACITY   = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  in_item_t  req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output out_item_t rsp
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int PTR_W = $clog2(CAPACITY + 1);

    logic              room;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [AW-1:0]     mem_waddr;
    logic              link_we;
    logic [PTR_W-1:0]  link_wdata;
    logic [PTR_W-1:0]  link_rdata;
    logic              val_we;
    logic [VALUE_W-1:0] val_wdata;
    logic [VALUE_W-1:0] val_rdata;
    res_t              res;

    mss_ram #(
        .WIDTH (PTR_W),
        .DEPTH (CAPACITY)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (mem_waddr),
        .wdata (link_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (link_rdata)
    );

    mss_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_value_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (mem_waddr),
        .wdata (val_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (val_rdata)
    );

    mss_ctrl #(
        .NUM_STACKS (NUM_STACKS),
        .CAPACITY   (CAPACITY)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .room       (room),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_waddr  (mem_waddr),
        .link_we    (link_we),
        .link_wdata (link_wdata),
        .link_rdata (link_rdata),
        .val_we     (val_we),
        .val_wdata  (val_wdata),
        .val_rdata  (val_rdata),
        .res        (res)
    );

    mss_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .room      (room),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

// ===== tb/shared_store_multi_stack_tb.sv =====
// Testbench for shared_store_multi_stack: directed and random stack traffic vs. a predictor
`timescale 1ns / 1ps
module shared_store_multi_stack_tb;
    import mss_pkg::*;

    localparam int NUM_STACKS = 4;
    localparam int CAPACITY   = 64;
    localparam int LINK_W     = 7;
    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(CAPACITY);
    localparam int HOLD_CYCLES = 80;
    localparam int MAX_REPORTS = 10;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    in_item_t  req;
    logic      rsp_valid;
    logic      rsp_ready;
    out_item_t rsp;

    shared_store_multi_stack #(
        .NUM_STACKS(NUM_STACKS),
        .CAPACITY  (CAPACITY)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic signed [VALUE_W-1:0] value_store [CAPACITY];
    logic [LINK_W-1:0]         slot_link   [CAPACITY];
    logic [LINK_W-1:0]         stack_top   [NUM_STACKS];
    logic [LINK_W-1:0]         free_head;
    int                        stack_depth [NUM_STACKS];
    int                        slots_in_use;

    out_item_t awaited_rsp [$];

    int  bad_count;
    int  n_push_done, n_push_full, n_pop_done, n_pop_empty, n_fills;
    bit  src_idle_on;
    bit  sink_idle_on;
    bit  hold_request;

    function automatic void log_error(input string msg);
        bad_count++;
        if (bad_count <= MAX_REPORTS)
        begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endfunction

    // apply one stack operation to the predictor and queue its response
    function automatic void stack_update(input in_item_t op);
        out_item_t           want;
        logic [LINK_W-1:0]   slot;
        logic [STACK_ID_W-1:0] sid;
        sid = op.stack_id;
        want.status    = STATUS_DONE;
        want.pop_value = PUSH_RSP_VALUE;
        if (op.action == ACT_PUSH)
        begin
            slot = free_head;
            if (int'(sid) >= NUM_STACKS || slot >= LINK_NULL)
            begin
                want.status = STATUS_FULL;
                n_push_full++;
            end
            else
            begin
                free_head         = slot_link[slot];
                value_store[slot] = op.push_value;
                slot_link[slot]   = stack_top[sid];
                stack_top[sid]    = slot;
                stack_depth[sid]++;
                slots_in_use++;
                n_push_done++;
                if (slots_in_use == CAPACITY)
                begin
                    n_fills++;
                end
            end
        end
        else
        begin
            if (int'(sid) >= NUM_STACKS || stack_top[sid] >= LINK_NULL)
            begin
                want.status    = STATUS_EMPTY;
                want.pop_value = EMPTY_POP_VALUE;
                n_pop_empty++;
            end
            else
            begin
                slot            = stack_top[sid];
                stack_top[sid]  = slot_link[slot];
                slot_link[slot] = free_head;
                free_head       = slot;
                want.pop_value  = value_store[slot];
                stack_depth[sid]--;
                slots_in_use--;
                n_pop_done++;
            end
        end
        awaited_rsp = {awaited_rsp, want};
    endfunction

    function automatic logic signed [VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return 32'sh0000_0000;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [STACK_ID_W-1:0] rand_stack(input bit prefer_nonempty);
        logic [STACK_ID_W-1:0] sid;
        sid = STACK_ID_W'($urandom_range(0, NUM_STACKS - 1));
        if (prefer_nonempty && stack_depth[sid] == 0 && $urandom_range(0, 3) != 0)
        begin
            for (int s = 0; s < NUM_STACKS; s++)
            begin
                if (stack_depth[s] != 0)
                begin
                    sid = STACK_ID_W'(s);
                end
            end
        end
        return sid;
    endfunction

    // one request transfer; valid stays high across back-to-back items
    task automatic send_op(input logic act, input logic [STACK_ID_W-1:0] sid,
                           input logic signed [VALUE_W-1:0] val);
        in_item_t op;
        in_item_t junk;
        begin
            op.action     = act;
            op.stack_id   = sid;
            op.push_value = val;
            if (src_idle_on && $urandom_range(0, 3) == 0)
            begin
                junk.action     = 1'($urandom);
                junk.stack_id   = STACK_ID_W'($urandom);
                junk.push_value = $urandom;
                req_valid <= 1'b0;
                req       <= junk;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            req_valid <= 1'b1;
            req       <= op;
            @(posedge clk);
            while (!req_ready)
            begin
                @(posedge clk);
            end
            stack_update(op);
        end
    endtask

    task automatic send_random(input int push_pct);
        begin
            if ($urandom_range(0, 99) < push_pct)
            begin
                send_op(ACT_PUSH, rand_stack(1'b0), rand_value());
            end
            else
            begin
                send_op(ACT_POP, rand_stack(1'b1), rand_value());
            end
        end
    endtask

    task automatic wait_drained();
        begin
            req_valid <= 1'b0;
            while (awaited_rsp.size() != 0)
            begin
                @(posedge clk);
            end
            repeat (4) @(posedge clk);
        end
    endtask

    task automatic test_empty_pops();
        begin
            for (int s = 0; s < NUM_STACKS; s++)
            begin
                send_op(ACT_POP, STACK_ID_W'(s), rand_value());
            end
            wait_drained();
        end
    endtask

    task automatic test_value_extremes();
        begin
            send_op(ACT_PUSH, 2'd0, 32'sh7fff_ffff);
            send_op(ACT_PUSH, 2'd1, 32'sh8000_0000);
            send_op(ACT_PUSH, 2'd2, 32'sh0000_0000);
            send_op(ACT_PUSH, 2'd3, -32'sd1);
            send_op(ACT_PUSH, 2'd0, 32'sh5555_5555);
            send_op(ACT_PUSH, 2'd2, 32'shaaaa_aaaa);
            send_op(ACT_POP,  2'd0, 32'sh1234_5678);
            send_op(ACT_POP,  2'd0, 32'sh0);
            send_op(ACT_POP,  2'd0, 32'sh0);
            send_op(ACT_POP,  2'd2, 32'sh0);
            for (int s = 1; s < NUM_STACKS; s++)
            begin
                send_op(ACT_POP, STACK_ID_W'(s), -32'sd1);
            end
            wait_drained();
        end
    endtask

    task automatic test_random_mix(input int n);
        begin
            repeat (n) send_random(50);
            wait_drained();
        end
    endtask

    // fill the whole store, push into it while full, then empty it again
    task automatic test_fill_and_drain();
        begin
            while (slots_in_use < CAPACITY)
            begin
                send_random(85);
            end
            repeat (6) send_op(ACT_PUSH, rand_stack(1'b0), rand_value());
            while (slots_in_use > 0)
            begin
                send_random(15);
            end
            repeat (4) send_op(ACT_POP, rand_stack(1'b0), rand_value());
            wait_drained();
        end
    endtask

    task automatic test_receiver_hold();
        begin
            hold_request = 1'b1;
            repeat (12) send_random(60);
            wait_drained();
        end
    endtask

    task automatic test_streaming(input int n);
        begin
            src_idle_on  = 1'b0;
            sink_idle_on = 1'b0;
            repeat (n) send_random(55);
            wait_drained();
        end
    endtask

    // response ready: random stall bursts, plus one long hold on request
    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (sink_idle_on && $urandom_range(0, 4) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 4) - 1) @(posedge clk);
            end
            else
            begin
                rsp_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : rsp_check
        out_item_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (awaited_rsp.size() == 0)
            begin
                log_error($sformatf("response with none pending: status %0d value %0d",
                                    rsp.status, rsp.pop_value));
            end
            else
            begin
                want = awaited_rsp.pop_front();
                if (rsp.status !== want.status)
                begin
                    log_error($sformatf("status expected %0d actual %0d",
                                        want.status, rsp.status));
                end
                if (rsp.pop_value !== want.pop_value)
                begin
                    log_error($sformatf("pop_value expected %0d actual %0d",
                                        want.pop_value, rsp.pop_value));
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        bad_count    = 0;
        n_push_done  = 0;
        n_push_full  = 0;
        n_pop_done   = 0;
        n_pop_empty  = 0;
        n_fills      = 0;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        hold_request = 1'b0;
        slots_in_use = 0;
        free_head    = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            value_store[i] = '0;
            slot_link[i]   = LINK_W'(i + 1);
        end
        for (int s = 0; s < NUM_STACKS; s++)
        begin
            stack_top[s]   = LINK_NULL;
            stack_depth[s] = 0;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_pops();
        test_value_extremes();
        test_random_mix(110);
        test_fill_and_drain();
        test_receiver_hold();
        test_streaming(140);

        if (awaited_rsp.size() != 0)
        begin
            log_error($sformatf("%0d responses never arrived", awaited_rsp.size()));
        end
        $display("covered %0d pushes stored, %0d refused on a full store, %0d pops, %0d on empty stacks",
                 n_push_done, n_push_full, n_pop_done, n_pop_empty);
        $display("store filled %0d time(s), one %0d-cycle receiver hold, %0d error(s)",
                 n_fills, HOLD_CYCLES, bad_count);
        if (bad_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/mss_pkg.sv
rtl/mss_ram.sv
rtl/mss_ctrl.sv
rtl/mss_outq.sv
rtl/shared_store_multi_stack.sv
tb/shared_store_multi_stack_tb.sv
